@@ design/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants of the sorted free-list heap allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int LEN_W    = 37;  // chunk length and byte count width
  localparam int SIZE_W   = 38;  // aligned request size width
  localparam int GROW_W   = 39;  // heap top after a grant
  localparam int NEED_W   = 40;  // heap top rounded to the growth step
  localparam int OUT_AW   = 48;  // address width on the ports
  localparam int CFG_W    = 48;  // widest configuration register
  localparam int CFG_IW   = 2;

  localparam int HEADER_BYTES       = 16;
  localparam int INITIAL_AREA_BYTES = 262144;

  localparam logic [47:0] HEAP_BASE_RST  = 48'h10_0000_0000;
  localparam logic [36:0] HEAP_LIMIT_RST = 37'h10_0000_0000;
  localparam logic [3:0]  ALIGN_RST      = 4'd4;
  localparam logic [4:0]  INC_RST        = 5'd16;

  localparam logic [CFG_IW-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEAP_LIMIT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ALIGN      = 2'd2;
  localparam logic [CFG_IW-1:0] REG_INCREMENT  = 2'd3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEM     = 2'd1,
    ST_TABLE_FULL = 2'd2
  } reply_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REMOVE,
    S_INSERT,
    S_GROW,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_DECIDE,
    OP_REMOVE,
    OP_INSERT,
    OP_GROW,
    OP_DELIVER
  } op_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
    logic need_remove;
    logic need_insert;
    logic need_grow;
    logic ins_planned;
    logic rm_done;
    logic ins_done;
  } stat_t;

endpackage

@@ design/sfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfla_ctrl
// Request sequencer: scan, decide, remove, insert, grow and result handoff.
// ----------------------------------------------------------------------------
module sfla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sfla_pkg::stat_t  stat,
  output sfla_pkg::op_t    op
);

  sfla_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             deliver;

  assign deliver = (state_r == sfla_pkg::S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfla_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sfla_pkg::S_SCAN;
      end
      sfla_pkg::S_SCAN: begin
        if (stat.scan_hit || stat.scan_miss) state_nxt = sfla_pkg::S_DECIDE;
      end
      sfla_pkg::S_DECIDE: begin
        if (stat.need_remove)      state_nxt = sfla_pkg::S_REMOVE;
        else if (stat.need_insert) state_nxt = sfla_pkg::S_INSERT;
        else if (stat.need_grow)   state_nxt = sfla_pkg::S_GROW;
        else                       state_nxt = sfla_pkg::S_DONE;
      end
      sfla_pkg::S_REMOVE: begin
        if (stat.rm_done) begin
          state_nxt = stat.ins_planned ? sfla_pkg::S_INSERT : sfla_pkg::S_DONE;
        end
      end
      sfla_pkg::S_INSERT: begin
        if (stat.ins_done) state_nxt = sfla_pkg::S_DONE;
      end
      sfla_pkg::S_GROW: begin
        state_nxt = sfla_pkg::S_DONE;
      end
      sfla_pkg::S_DONE: begin
        if (deliver) state_nxt = sfla_pkg::S_IDLE;
      end
      default: state_nxt = sfla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op       = sfla_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state_r)
      sfla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = sfla_pkg::OP_LOAD;
      end
      sfla_pkg::S_SCAN:   op = sfla_pkg::OP_SCAN;
      sfla_pkg::S_DECIDE: op = sfla_pkg::OP_DECIDE;
      sfla_pkg::S_REMOVE: op = sfla_pkg::OP_REMOVE;
      sfla_pkg::S_INSERT: op = sfla_pkg::OP_INSERT;
      sfla_pkg::S_GROW:   op = sfla_pkg::OP_GROW;
      sfla_pkg::S_DONE: begin
        if (deliver) op = sfla_pkg::OP_DELIVER;
      end
      default: op = sfla_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (deliver)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/sfla_dp.sv @@
// ----------------------------------------------------------------------------
// sfla_dp
// Datapath: free-chunk table memory, scan and shift counters, heap growth
// arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module sfla_dp #(
  parameter int N  = 16,
  parameter int AW = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sfla_pkg::op_t                     op,
  output sfla_pkg::stat_t                   stat,
  input  logic                              in_mode,
  input  logic [sfla_pkg::LEN_W-1:0]        in_byte_count,
  input  logic [sfla_pkg::OUT_AW-1:0]       in_chunk_address,
  input  logic                              cfg_we,
  input  logic [sfla_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [sfla_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [sfla_pkg::OUT_AW-1:0]       out_granted_address,
  output logic [1:0]                        out_status
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int LW = sfla_pkg::LEN_W;
  localparam int SW = sfla_pkg::SIZE_W;
  localparam int GW = sfla_pkg::GROW_W;
  localparam int NW = sfla_pkg::NEED_W;

  // Table memory, sorted by ascending length.
  logic [AW-1:0] mem_start [N];
  logic [LW-1:0] mem_len   [N];
  logic [AW-1:0] rd_start_r;
  logic [LW-1:0] rd_len_r;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [AW-1:0] wr_start;
  logic [LW-1:0] wr_len;

  // Control registers.
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic          hit_r, hit_nxt;
  logic          ins_plan_r, ins_plan_nxt;
  logic [LW-1:0] heap_used_r, heap_used_nxt;
  logic [LW-1:0] area_r, area_nxt;
  logic [47:0]   base_r, base_nxt;
  logic [36:0]   limit_r, limit_nxt;
  logic [3:0]    align_r, align_nxt;
  logic [4:0]    inc_r, inc_nxt;

  // Payload registers.
  logic [IW-1:0]         pend_idx_r, pend_idx_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [AW-1:0]         hit_start_r, hit_start_nxt;
  logic [LW-1:0]         hit_len_r, hit_len_nxt;
  logic                  mode_r, mode_nxt;
  logic [LW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [SW-1:0]         size_r, size_nxt;
  logic [AW-1:0]         new_start_r, new_start_nxt;
  logic [LW-1:0]         new_len_r, new_len_nxt;
  logic [GW-1:0]         grown_r, grown_nxt;
  logic [AW-1:0]         res_addr_r, res_addr_nxt;
  sfla_pkg::reply_code_t res_status_r, res_status_nxt;
  logic [sfla_pkg::OUT_AW-1:0] out_addr_r, out_addr_nxt;
  sfla_pkg::reply_code_t out_status_r, out_status_nxt;

  // Combinational helpers.
  logic [SW-1:0] amask, size_in;
  logic          issue_up, match, match_alloc, match_rel;
  logic [AW-1:0] end_of_rd, end_of_ptr;
  logic [CW-1:0] k_dec;
  logic          stop, ins_issue, ins_done, rm_done;
  logic [GW-1:0] split_lim;
  logic          split, full;
  logic [SW-1:0] msum;
  logic [LW-1:0] merged;
  logic [NW-1:0] inc_mask, needed;
  logic          over_area, over_limit;
  logic          need_insert;

  assign amask      = (SW'(1) << align_r) - SW'(1);
  assign size_in    = ({1'b0, in_byte_count} + amask) & ~amask;
  assign issue_up   = iss_r < used_r;
  assign k_dec      = k_r - CW'(1);
  assign match_alloc = {1'b0, rd_len_r} >= size_r;
  assign end_of_rd  = rd_start_r + AW'(rd_len_r);
  assign end_of_ptr = ptr_r + AW'(count_r);
  assign match_rel  = (end_of_rd == ptr_r) || (end_of_ptr == rd_start_r);
  assign match      = mode_r ? match_rel : match_alloc;
  // Insert walks down from the top; it stops at the first shorter entry.
  assign stop       = pend_vld_r && (rd_len_r < new_len_r);
  assign ins_issue  = (k_r != '0) && !stop;
  assign ins_done   = stop || (!pend_vld_r && (k_r == '0));
  assign rm_done    = !pend_vld_r && !issue_up;
  assign split_lim  = {1'b0, size_r} + GW'(sfla_pkg::HEADER_BYTES);
  assign split      = {2'b00, hit_len_r} > split_lim;
  assign full       = used_r == CW'(N);
  assign msum       = {1'b0, hit_len_r} + {1'b0, count_r};
  assign merged     = msum[SW-1] ? '1 : msum[LW-1:0];
  assign inc_mask   = (NW'(1) << inc_r) - NW'(1);
  assign needed     = ({1'b0, grown_r} + inc_mask) & ~inc_mask;
  assign over_area  = needed > NW'(area_r);
  assign over_limit = needed > NW'(limit_r);
  assign need_insert = mode_r ? (hit_r || !full) : (hit_r && split);

  always_comb begin
    stat             = '0;
    stat.scan_hit    = (op == sfla_pkg::OP_SCAN) && pend_vld_r && match;
    stat.scan_miss   = (op == sfla_pkg::OP_SCAN) && !pend_vld_r && !issue_up;
    stat.need_remove = hit_r;
    stat.need_insert = need_insert;
    stat.need_grow   = !mode_r && !hit_r;
    stat.ins_planned = ins_plan_r;
    stat.rm_done     = rm_done;
    stat.ins_done    = ins_done;
  end

  // Memory port control.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = iss_r[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = pend_idx_r;
    wr_start = rd_start_r;
    wr_len   = rd_len_r;
    case (op)
      sfla_pkg::OP_SCAN: begin
        rd_en = issue_up;
      end
      sfla_pkg::OP_REMOVE: begin
        rd_en   = issue_up;
        wr_en   = pend_vld_r;
        wr_addr = pend_idx_r - IW'(1);
      end
      sfla_pkg::OP_INSERT: begin
        rd_en   = ins_issue;
        rd_addr = k_dec[IW-1:0];
        if (pend_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r + IW'(1);
          if (stop) begin
            wr_start = new_start_r;
            wr_len   = new_len_r;
          end
        end else if (k_r == '0) begin
          wr_en    = 1'b1;
          wr_addr  = '0;
          wr_start = new_start_r;
          wr_len   = new_len_r;
        end
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    if (rd_en) begin
      rd_start_r <= mem_start[rd_addr];
      rd_len_r   <= mem_len[rd_addr];
    end
  end

  always_comb begin
    used_nxt       = used_r;
    iss_nxt        = iss_r;
    k_nxt          = k_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    hit_nxt        = hit_r;
    ins_plan_nxt   = ins_plan_r;
    heap_used_nxt  = heap_used_r;
    area_nxt       = area_r;
    hit_idx_nxt    = hit_idx_r;
    hit_start_nxt  = hit_start_r;
    hit_len_nxt    = hit_len_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    size_nxt       = size_r;
    new_start_nxt  = new_start_r;
    new_len_nxt    = new_len_r;
    grown_nxt      = grown_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    case (op)
      sfla_pkg::OP_LOAD: begin
        mode_nxt     = in_mode;
        count_nxt    = in_byte_count;
        ptr_nxt      = AW'(in_chunk_address);
        size_nxt     = size_in;
        iss_nxt      = '0;
        pend_vld_nxt = 1'b0;
        hit_nxt      = 1'b0;
      end
      sfla_pkg::OP_SCAN: begin
        iss_nxt      = iss_r + CW'(issue_up);
        pend_vld_nxt = issue_up;
        pend_idx_nxt = iss_r[IW-1:0];
        if (pend_vld_r && match) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = pend_idx_r;
          hit_start_nxt = rd_start_r;
          hit_len_nxt   = rd_len_r;
        end
      end
      sfla_pkg::OP_DECIDE: begin
        ins_plan_nxt = need_insert;
        iss_nxt      = CW'(hit_idx_r) + CW'(1);
        pend_vld_nxt = 1'b0;
        k_nxt        = used_r - CW'(hit_r);
        grown_nxt    = GW'(heap_used_r) + GW'(size_r);
        res_addr_nxt   = '0;
        res_status_nxt = sfla_pkg::ST_OK;
        if (!mode_r) begin
          res_addr_nxt  = hit_start_r;
          new_start_nxt = hit_start_r + AW'(size_r);
          new_len_nxt   = hit_len_r - size_r[LW-1:0];
        end else if (hit_r) begin
          new_start_nxt = (hit_start_r < ptr_r) ? hit_start_r : ptr_r;
          new_len_nxt   = merged;
        end else begin
          new_start_nxt = ptr_r;
          new_len_nxt   = count_r;
          if (full) res_status_nxt = sfla_pkg::ST_TABLE_FULL;
        end
      end
      sfla_pkg::OP_REMOVE: begin
        iss_nxt      = iss_r + CW'(issue_up);
        pend_vld_nxt = issue_up;
        pend_idx_nxt = iss_r[IW-1:0];
        if (rm_done) used_nxt = used_r - CW'(1);
      end
      sfla_pkg::OP_INSERT: begin
        pend_vld_nxt = ins_issue;
        pend_idx_nxt = k_dec[IW-1:0];
        if (ins_issue) k_nxt = k_dec;
        if (ins_done) used_nxt = used_r + CW'(1);
      end
      sfla_pkg::OP_GROW: begin
        if (over_area && over_limit) begin
          res_addr_nxt   = '0;
          res_status_nxt = sfla_pkg::ST_NO_MEM;
        end else begin
          if (over_area) area_nxt = needed[LW-1:0];
          res_addr_nxt   = AW'(base_r) + AW'(heap_used_r);
          res_status_nxt = sfla_pkg::ST_OK;
          heap_used_nxt  = grown_r[LW-1:0];
        end
      end
      sfla_pkg::OP_DELIVER: begin
        out_addr_nxt   = sfla_pkg::OUT_AW'(res_addr_r);
        out_status_nxt = res_status_r;
      end
      default: used_nxt = used_r;
    endcase
  end

  always_comb begin
    base_nxt  = base_r;
    limit_nxt = limit_r;
    align_nxt = align_r;
    inc_nxt   = inc_r;
    if (cfg_we) begin
      case (cfg_index)
        sfla_pkg::REG_HEAP_BASE:  base_nxt  = cfg_wdata[47:0];
        sfla_pkg::REG_HEAP_LIMIT: limit_nxt = cfg_wdata[36:0];
        sfla_pkg::REG_ALIGN:      align_nxt = cfg_wdata[3:0];
        sfla_pkg::REG_INCREMENT:  inc_nxt   = cfg_wdata[4:0];
        default:                  base_nxt  = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      iss_r       <= '0;
      k_r         <= '0;
      pend_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      ins_plan_r  <= 1'b0;
      heap_used_r <= '0;
      area_r      <= LW'(sfla_pkg::INITIAL_AREA_BYTES);
      base_r      <= sfla_pkg::HEAP_BASE_RST;
      limit_r     <= sfla_pkg::HEAP_LIMIT_RST;
      align_r     <= sfla_pkg::ALIGN_RST;
      inc_r       <= sfla_pkg::INC_RST;
    end else begin
      used_r      <= used_nxt;
      iss_r       <= iss_nxt;
      k_r         <= k_nxt;
      pend_vld_r  <= pend_vld_nxt;
      hit_r       <= hit_nxt;
      ins_plan_r  <= ins_plan_nxt;
      heap_used_r <= heap_used_nxt;
      area_r      <= area_nxt;
      base_r      <= base_nxt;
      limit_r     <= limit_nxt;
      align_r     <= align_nxt;
      inc_r       <= inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_start_r  <= hit_start_nxt;
    hit_len_r    <= hit_len_nxt;
    mode_r       <= mode_nxt;
    count_r      <= count_nxt;
    ptr_r        <= ptr_nxt;
    size_r       <= size_nxt;
    new_start_r  <= new_start_nxt;
    new_len_r    <= new_len_nxt;
    grown_r      <= grown_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

endmodule

@@ design/sorted_free_list_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// sorted_free_list_heap_allocator
// Best-fit heap allocator with a size-sorted free-chunk table and coalescing.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready): in_mode 0 allocates
// in_byte_count bytes, in_mode 1 releases the chunk at in_chunk_address.
// Every request yields exactly one result on the out_ channel: the granted
// address and a status (ok, out of memory, free table full).
// One request is worked on at a time. From acceptance to result a request
// passes a scan of the table through its single read port (one entry per
// cycle), a removal that shifts the entries above the chosen one down, and a
// sorted insert that shifts larger entries up, each one entry per cycle.
// A finished result sits in an output register; the next request is taken
// while it waits, and is held before its own handoff until out_ready frees
// the register. Configuration writes on cfg_ take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the table, clears the heap top and
// restores the configuration registers; the table memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_free_list_heap_allocator #(
  parameter int FREE_ENTRIES = 16,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [36:0]                 in_byte_count,
  input  logic [47:0]                 in_chunk_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [47:0]                 out_granted_address,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [47:0]                 cfg_wdata
);

  sfla_pkg::op_t   op;
  sfla_pkg::stat_t stat;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  sfla_dp #(
    .N  (FREE_ENTRIES),
    .AW (ADDRESS_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .stat                (stat),
    .in_mode             (in_mode),
    .in_byte_count       (in_byte_count),
    .in_chunk_address    (in_chunk_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

@@ design/sfla_chk.sv @@
// ----------------------------------------------------------------------------
// sfla_chk
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sfla_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_granted_address,
  input logic [1:0]  out_status
);

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_granted_address)
      && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= sfla_pkg::ST_TABLE_FULL)
    else $error("undefined status code");

  // A failed request never hands out an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sfla_pkg::ST_OK |-> out_granted_address == 48'd0)
    else $error("address returned with a failure status");

  // Only one request is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

endmodule

bind sorted_free_list_heap_allocator sfla_chk u_sfla_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_granted_address (out_granted_address),
  .out_status          (out_status)
);
